// File: hdl/serial_frame_receiver_with_sum_check_core_assert.svh
// assertion macros used by the frame parser module
`ifndef SERIAL_FRAME_RECEIVER_WITH_SUM_CHECK_CORE_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_WITH_SUM_CHECK_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfr assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define SFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfr assertion failed");

`endif

// File: hdl/sfr_pkg.sv
// shared types and constants for the serial frame receiver
package sfr_pkg;

    // framing bytes
    localparam logic [7:0] START_BYTE = 8'hAB;
    localparam logic [7:0] SYNC_HEAD  = 8'hAC;
    localparam logic [7:0] SYNC_TAIL  = 8'h01;

    // input transaction kinds
    localparam logic ITEM_BYTE = 1'b0;
    localparam logic ITEM_SYNC = 1'b1;

    // result kinds
    localparam logic [1:0] RES_PAYLOAD = 2'd0;
    localparam logic [1:0] RES_GOOD    = 2'd1;
    localparam logic [1:0] RES_BAD     = 2'd2;
    localparam logic [1:0] RES_SYNC    = 2'd3;

    // one input transaction
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } sfr_item_t;

    // one result transaction
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
    } sfr_result_t;

    // pipeline control from the top level to the parser
    typedef struct packed {
        logic fire;
        logic taken;
    } sfr_ctl_t;

endpackage

// File: hdl/serial_frame_receiver_with_sum_check_core.sv
// top level of the serial frame receiver with additive sum check
//
// Usage:
//   item channel (item_valid / item_stall): one transaction per link byte
//   (kind 0, rx_byte) or a sync search request (kind 1, rx_byte ignored).
//   result channel (result_valid / result_stall): payload bytes passed on
//   cut-through (out_kind 0), then a good or bad frame marker (1 or 2)
//   after the last sum byte, or sync achieved (3) once AC 01 is seen.
//   The consumer drops the payload of a frame that ends with a bad marker.
//   A result is loaded into the result register from the input register
//   once its transaction has been accepted there, and is taken from there.
//   Throughput: one transaction per cycle while result_stall is low, set
//   by the single phase update between the input and result registers.
//   Bytes that yield no result still pass through the input register.
//   Reset: both registers empty, the parser hunts for the start byte.
//   Stall: a held result stays on the outputs; the input register then
//   fills and item_stall rises while it holds a waiting transaction.

module serial_frame_receiver_with_sum_check_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte
);
    import sfr_pkg::*;

    logic        in_valid_reg, in_valid_next;
    sfr_item_t   in_item_reg, in_item_next;
    logic        res_ready;
    logic        accept;
    sfr_ctl_t    ctl;
    sfr_result_t result;

    // result register can take a new entry when empty or being drained
    assign res_ready  = !result.valid || !result_stall;
    assign ctl.fire   = in_valid_reg && res_ready;
    assign ctl.taken  = result.valid && !result_stall;
    assign item_stall = in_valid_reg && !res_ready;
    assign accept     = item_valid && !item_stall;

    // input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (ctl.fire)
        begin
            in_valid_next = 1'b0;
        end
        if (accept)
        begin
            in_valid_next     = 1'b1;
            in_item_next.kind = kind;
            in_item_next.data = rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    // frame parser with result register
    sfr_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (in_item_reg),
        .result (result)
    );

    assign result_valid = result.valid;
    assign out_kind     = result.kind;
    assign out_byte     = result.data;

endmodule

// File: hdl/sfr_parser.sv
// frame parser: phase machine, length and sum tracking, result register
`include "serial_frame_receiver_with_sum_check_core_assert.svh"

module sfr_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  sfr_pkg::sfr_ctl_t    ctl,
    input  sfr_pkg::sfr_item_t   item,
    output sfr_pkg::sfr_result_t result
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_SUM_HI,
        PH_SUM_LO,
        PH_SYNC,
        PH_SYNC_AC
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [7:0]  sum_high_reg, sum_high_next;
    sfr_result_t res_reg, res_next;

    logic [15:0] sum_plus;
    logic [15:0] length_full;
    logic [15:0] left_dec;
    logic [15:0] sum_got;

    assign sum_plus    = running_sum_reg + {8'h00, item.data};
    assign length_full = {frame_length_reg[15:8], item.data};
    assign left_dec    = bytes_left_reg - 16'd1;
    assign sum_got     = {sum_high_reg, item.data};

    // next state and result for the transaction in the input register
    always_comb
    begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        frame_length_next = frame_length_reg;
        running_sum_next  = running_sum_reg;
        sum_high_next     = sum_high_reg;
        res_next          = res_reg;

        if (ctl.taken)
        begin
            res_next.valid = 1'b0;
        end

        if (ctl.fire)
        begin
            res_next.valid = 1'b0;
            res_next.kind  = RES_PAYLOAD;
            res_next.data  = 8'h00;

            if (item.kind == ITEM_SYNC)
            begin
                // sync request abandons a frame in progress
                unique case (phase_reg)
                    PH_SYNC, PH_SYNC_AC:
                    begin
                    end
                    PH_HUNT:
                    begin
                        phase_next = PH_SYNC;
                    end
                    default:
                    begin
                        phase_next     = PH_SYNC;
                        res_next.valid = 1'b1;
                        res_next.kind  = RES_BAD;
                    end
                endcase
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (item.data == START_BYTE)
                        begin
                            running_sum_next  = {8'h00, START_BYTE};
                            frame_length_next = 16'h0000;
                            bytes_left_next   = 16'h0000;
                            sum_high_next     = 8'h00;
                            phase_next        = PH_LEN_HI;
                        end
                        else if (item.data == SYNC_HEAD)
                        begin
                            phase_next = PH_SYNC_AC;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        frame_length_next = {item.data, 8'h00};
                        running_sum_next  = sum_plus;
                        phase_next        = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        frame_length_next = length_full;
                        running_sum_next  = sum_plus;
                        if (length_full == 16'd0)
                        begin
                            phase_next     = PH_HUNT;
                            res_next.valid = 1'b1;
                            res_next.kind  = RES_BAD;
                        end
                        else if (length_full == 16'd1)
                        begin
                            phase_next = PH_SUM_LO;
                        end
                        else if (length_full == 16'd2)
                        begin
                            phase_next = PH_SUM_HI;
                        end
                        else
                        begin
                            bytes_left_next = length_full - 16'd2;
                            phase_next      = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        running_sum_next = sum_plus;
                        bytes_left_next  = left_dec;
                        if (left_dec == 16'd0)
                        begin
                            phase_next = PH_SUM_HI;
                        end
                        res_next.valid = 1'b1;
                        res_next.kind  = RES_PAYLOAD;
                        res_next.data  = item.data;
                    end
                    PH_SUM_HI:
                    begin
                        sum_high_next = item.data;
                        phase_next    = PH_SUM_LO;
                    end
                    PH_SUM_LO:
                    begin
                        // lengths below two never pass
                        phase_next     = PH_HUNT;
                        res_next.valid = 1'b1;
                        if (frame_length_reg >= 16'd2 && sum_got == running_sum_reg)
                        begin
                            res_next.kind = RES_GOOD;
                        end
                        else
                        begin
                            res_next.kind = RES_BAD;
                        end
                    end
                    PH_SYNC:
                    begin
                        if (item.data == SYNC_HEAD)
                        begin
                            phase_next = PH_SYNC_AC;
                        end
                    end
                    PH_SYNC_AC:
                    begin
                        if (item.data == SYNC_TAIL)
                        begin
                            phase_next     = PH_HUNT;
                            res_next.valid = 1'b1;
                            res_next.kind  = RES_SYNC;
                        end
                        else if (item.data == SYNC_HEAD)
                        begin
                            phase_next = PH_SYNC_AC;
                        end
                        else
                        begin
                            phase_next = PH_SYNC;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            bytes_left_reg   <= 16'h0000;
            frame_length_reg <= 16'h0000;
            running_sum_reg  <= 16'h0000;
            sum_high_reg     <= 8'h00;
            res_reg          <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            frame_length_reg <= frame_length_next;
            running_sum_reg  <= running_sum_next;
            sum_high_reg     <= sum_high_next;
            res_reg          <= res_next;
        end
    end

    assign result = res_reg;

    // checks
    `SFR_ASSERT_NOW(a_marker_data_zero,
        res_reg.valid && res_reg.kind != RES_PAYLOAD, res_reg.data == 8'h00)
    `SFR_ASSERT_NOW(a_data_phase_count,
        phase_reg == PH_DATA, bytes_left_reg != 16'd0)
    `SFR_ASSERT_NEXT(a_abandon_gives_bad,
        ctl.fire && item.kind == ITEM_SYNC && phase_reg != PH_HUNT
            && phase_reg != PH_SYNC && phase_reg != PH_SYNC_AC,
        res_reg.valid && res_reg.kind == RES_BAD && phase_reg == PH_SYNC)
    `SFR_ASSERT_NEXT(a_sync_pair_found,
        ctl.fire && item.kind == ITEM_BYTE && phase_reg == PH_SYNC_AC
            && item.data == SYNC_TAIL,
        res_reg.valid && res_reg.kind == RES_SYNC && phase_reg == PH_HUNT)

endmodule
